// ----- src/fbdq_pkg.sv -----
// shared codes and widths for the framed byte deque buffer
// no dependencies; imported by fbdq_store and framed_byte_deque_buffer_core
package fbdq_pkg;

  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int ST_W   = 3;
  localparam int FILL_W = 9;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;
  localparam logic [OP_W-1:0] OP_MSG_BACK   = 3'd6;
  localparam logic [OP_W-1:0] OP_MSG_FRONT  = 3'd7;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 3'd3;
  localparam logic [ST_W-1:0] ST_BUSY  = 3'd4;

  localparam logic [BYTE_W-1:0] END_MARKER_RST = 8'd33;

  // what the result register keeps besides the byte read from the store
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [FILL_W-1:0] fill_level;
    logic              is_end;
    logic              chk_end;
    logic              use_mem;
    logic [BYTE_W-1:0] const_byte;
  } result_t;

endpackage

// ----- src/fbdq_store.sv -----
// byte store of the deque: one write port, one read port with registered data
// depends on fbdq_pkg for the byte width
module fbdq_store import fbdq_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/framed_byte_deque_buffer_core.sv -----
// framed byte deque: ring of bytes with push/pop at both ends, peek, clear and messages
// depends on fbdq_pkg and fbdq_store
//
//  channel  dir  handshake              payload
//  s_axis   in   tvalid/tready          tuser op, tdata data/offset/length
//  m_axis   out  tvalid/tready          tuser status, tlast is_end, tdata byte/fill
//  cfg      in   cfg_wr_en              cfg_wr_data end marker
//
// one word is taken per cycle while s_axis_tready is high; its result is registered
// into the output register. a message start of nonzero length writes two store entries
// through the single write port, so s_axis_tready drops for one cycle after it.
// a stalled m_axis holds s_axis only once the output register is full.
// rst is synchronous; pointers, counts and message state clear, store contents
// are left as they are.
module framed_byte_deque_buffer_core import fbdq_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // data_byte[7:0], peek_offset[15:8], message_length[23:16]
  input  logic [2:0]  s_axis_tuser,   // operation[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // read_byte[7:0], fill_level[16:8], zero[23:17]
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  output logic        m_axis_tlast,   // is_end
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = ((CW > 9) ? CW : 9) + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  // wrap a sum below twice the depth back into the ring
  function automatic logic [AW-1:0] ring(input logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = (s >= DEPTH_S) ? s - DEPTH_S : s;
    return t[AW-1:0];
  endfunction

  logic [BYTE_W-1:0] end_marker;
  logic [AW-1:0]     head, head_next;
  logic [CW-1:0]     count, count_next;
  logic              msg_open, msg_open_next;
  logic              msg_rej, msg_rej_next;
  logic [AW-1:0]     msg_idx, msg_idx_next;
  logic [7:0]        msg_left, msg_left_next;
  logic              pend_valid;
  logic [AW-1:0]     pend_addr;
  logic [BYTE_W-1:0] pend_data;
  logic              out_valid;
  result_t           res, res_next;

  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] din;
  logic [7:0]        off;
  logic [7:0]        len;
  logic              accept;
  logic              wr_en, rd_en, pend_set;
  logic [AW-1:0]     wr_addr, rd_addr, pend_addr_next, base;
  logic [BYTE_W-1:0] wr_data;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] mem_q;
  logic [BYTE_W-1:0] read_byte;

  assign op  = s_axis_tuser;
  assign din = s_axis_tdata[7:0];
  assign off = s_axis_tdata[15:8];
  assign len = s_axis_tdata[23:16];

  assign s_axis_tready = !pend_valid && (!out_valid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    head_next      = head;
    count_next     = count;
    msg_open_next  = msg_open;
    msg_rej_next   = msg_rej;
    msg_idx_next   = msg_idx;
    msg_left_next  = msg_left;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = din;
    rd_en          = 1'b0;
    rd_addr        = '0;
    pend_set       = 1'b0;
    pend_addr_next = '0;
    base           = '0;
    res_next       = '0;
    res_next.status = ST_OK;

    if (msg_open) begin
      if (op == OP_MSG_BACK || op == OP_MSG_FRONT) begin
        if (msg_rej) begin
          res_next.status = ST_FULL;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = msg_idx;
          msg_idx_next = ring(SW'(msg_idx) + SW'(1));
        end
        msg_left_next = msg_left - 8'd1;
        if (msg_left == 8'd1) begin
          msg_open_next = 1'b0;
          msg_rej_next  = 1'b0;
        end
      end else begin
        res_next.status = ST_BUSY;
      end
    end else begin
      case (op)
        OP_PUSH_BACK: begin
          if (count == DEPTH_C) begin
            res_next.status = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = ring(SW'(head) + SW'(count));
            count_next = count + CW'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (count == DEPTH_C) begin
            res_next.status = ST_FULL;
          end else begin
            head_next  = (head == '0) ? LAST_IDX : head - AW'(1);
            wr_en      = 1'b1;
            wr_addr    = head_next;
            count_next = count + CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (count == '0) begin
            res_next.status     = ST_EMPTY;
            res_next.const_byte = end_marker;
            res_next.is_end     = 1'b1;
          end else begin
            rd_en            = 1'b1;
            rd_addr          = head;
            res_next.use_mem = 1'b1;
            res_next.chk_end = 1'b1;
            head_next        = ring(SW'(head) + SW'(1));
            count_next       = count - CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (count == '0) begin
            res_next.status = ST_EMPTY;
          end else begin
            rd_en            = 1'b1;
            rd_addr          = ring(SW'(head) + SW'(count) - SW'(1));
            res_next.use_mem = 1'b1;
            count_next       = count - CW'(1);
          end
        end
        OP_PEEK: begin
          if (SW'(off) >= SW'(count)) begin
            res_next.status = ST_RANGE;
          end else begin
            rd_en            = 1'b1;
            rd_addr          = ring(SW'(head) + SW'(off));
            res_next.use_mem = 1'b1;
          end
        end
        OP_CLEAR: begin
          head_next  = '0;
          count_next = '0;
        end
        OP_MSG_BACK, OP_MSG_FRONT: begin
          if (SW'(count) + SW'(len) >= DEPTH_S) begin
            res_next.status = ST_FULL;
            if (len > 8'd1) begin
              msg_open_next = 1'b1;
              msg_rej_next  = 1'b1;
              msg_left_next = len - 8'd1;
            end
          end else begin
            if (op == OP_MSG_FRONT) begin
              base      = ring(SW'(head) + DEPTH_S - SW'(len) - SW'(1));
              head_next = base;
            end else begin
              base = ring(SW'(head) + SW'(count));
            end
            count_next = CW'(SW'(count) + SW'(len) + SW'(1));
            wr_en      = 1'b1;
            if (len == 8'd0) begin
              wr_addr = base;
              wr_data = end_marker;
            end else begin
              // first byte now, end marker on the following cycle
              wr_addr        = base;
              pend_set       = 1'b1;
              pend_addr_next = ring(SW'(base) + SW'(len));
            end
            if (len > 8'd1) begin
              msg_open_next = 1'b1;
              msg_rej_next  = 1'b0;
              msg_idx_next  = ring(SW'(base) + SW'(1));
              msg_left_next = len - 8'd1;
            end
          end
        end
        default: begin
          res_next.status = ST_OK;
        end
      endcase
    end
    res_next.fill_level = FILL_W'(count_next);
  end

  // a pending marker only exists while no word is taken
  assign mem_we    = pend_valid || (accept && wr_en);
  assign mem_waddr = pend_valid ? pend_addr : wr_addr;
  assign mem_wdata = pend_valid ? pend_data : wr_data;

  fbdq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept && rd_en),
    .raddr (rd_addr),
    .rdata (mem_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      end_marker <= END_MARKER_RST;
    end else if (cfg_wr_en) begin
      end_marker <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      msg_open   <= 1'b0;
      msg_rej    <= 1'b0;
      msg_idx    <= '0;
      msg_left   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        head       <= head_next;
        count      <= count_next;
        msg_open   <= msg_open_next;
        msg_rej    <= msg_rej_next;
        msg_idx    <= msg_idx_next;
        msg_left   <= msg_left_next;
        pend_valid <= pend_set;
        out_valid  <= 1'b1;
      end else begin
        pend_valid <= 1'b0;
        if (m_axis_tready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
      if (pend_set) begin
        pend_addr <= pend_addr_next;
        pend_data <= end_marker;
      end
    end
  end

  assign read_byte     = res.use_mem ? mem_q : res.const_byte;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, res.fill_level, read_byte};
  assign m_axis_tuser  = res.status;
  assign m_axis_tlast  = res.is_end || (res.chk_end && (mem_q == end_marker));

endmodule
